// ===== rtl/core/one_time_nonce_replay_bitmap_top_defines.svh =====
// assertion macros shared by the nonce replay bitmap rtl
// no dependencies; included by the files that carry assertions
`ifndef ONE_TIME_NONCE_REPLAY_BITMAP_TOP_DEFINES_SVH
`define ONE_TIME_NONCE_REPLAY_BITMAP_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define OTN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define OTN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define OTN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define OTN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/otn_pkg.sv =====
// shared types and codes for the nonce replay bitmap
// no dependencies; imported by the controller, datapath and top level
package otn_pkg;

    localparam int POOL_BITS_W = 4;
    localparam int NONCE_W     = 32;
    localparam int POOL_W      = 10;
    localparam int STATUS_W    = 2;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 40;

    localparam logic FUNC_ISSUE = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_POOL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_REPLAY   = 2'd3;

    typedef struct packed {
        logic clear;
        logic load_in;
        logic calc1;
        logic calc2;
        logic calc3;
        logic calc4;
        logic modify;
        logic load_out;
    } otn_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_free;
    } otn_sts_t;

endpackage

// ===== rtl/core/otn_ctrl.sv =====
// controller state machine for the nonce replay bitmap
// depends on otn_pkg and the shared assertion macro header
`include "one_time_nonce_replay_bitmap_top_defines.svh"

module otn_ctrl
    import otn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  otn_sts_t  sts,
    output otn_cmd_t  cmd
);

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_CALC1 = 8'b0000_0100,
        ST_CALC2 = 8'b0000_1000,
        ST_CALC3 = 8'b0001_0000,
        ST_CALC4 = 8'b0010_0000,
        ST_MOD   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_CALC1;
                end
            end
            ST_CALC1:
            begin
                cmd.calc1  = 1'b1;
                state_next = ST_CALC2;
            end
            ST_CALC2:
            begin
                cmd.calc2  = 1'b1;
                state_next = ST_CALC3;
            end
            ST_CALC3:
            begin
                cmd.calc3  = 1'b1;
                state_next = ST_CALC4;
            end
            ST_CALC4:
            begin
                cmd.calc4  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.modify = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.load_out = sts.out_free;
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // one request in flight at a time
    `OTN_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `OTN_ASSERT_IMP(a_no_accept_in_clear, clk, rst_n, cmd.clear, !cmd.load_in)

endmodule

// ===== rtl/core/otn_datapath.sv =====
// datapath of the nonce replay bitmap: index arithmetic, bitmap memory, result register
// depends on otn_pkg and the shared assertion macro header
`include "one_time_nonce_replay_bitmap_top_defines.svh"

module otn_datapath
    import otn_pkg::*;
#(
    parameter int IN_FLIGHT_LOG2 = 16,
    parameter int CELL_BITS      = 32,
    parameter int ID_STEP        = 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [POOL_BITS_W-1:0] cfg_wdata,
    input  logic                   func,
    input  logic [NONCE_W-1:0]     nonce_id,
    input  logic [POOL_W-1:0]      pool,
    input  logic [NONCE_W-1:0]     current_id,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [STATUS_W-1:0]    status,
    output logic [NONCE_W-1:0]     id_echo,
    input  otn_cmd_t               cmd,
    output otn_sts_t               sts
);

    localparam int BIT_W     = IN_FLIGHT_LOG2;
    localparam int NUM_CELLS = ((1 << IN_FLIGHT_LOG2) + CELL_BITS - 1) / CELL_BITS;
    localparam int CELL_AW   = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int OFF_W     = $clog2(CELL_BITS);
    localparam int K_W       = $clog2(IN_FLIGHT_LOG2 + 1);
    localparam int WIN_W     = $clog2(ID_STEP + 1) + IN_FLIGHT_LOG2;
    localparam int CMP_W     = (WIN_W > NONCE_W) ? WIN_W : NONCE_W;
    // reciprocal of the cell width, exact for every bit index below 2^BIT_W
    localparam int SH        = BIT_W + OFF_W;
    localparam int RECIP_W   = BIT_W + 2;
    localparam int PROD_W    = BIT_W + RECIP_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << SH) + 64'(CELL_BITS) - 64'd1) / 64'(CELL_BITS);
    localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

    // configuration
    logic [POOL_BITS_W-1:0] pool_bits_reg;

    // captured request
    logic                   func_reg;
    logic [NONCE_W-1:0]     nonce_reg;
    logic [POOL_W-1:0]      pool_reg;
    logic [NONCE_W-1:0]     cur_reg;

    // index arithmetic
    logic [POOL_BITS_W-1:0] pb_eff;
    logic [K_W-1:0]         part_k_next;
    logic [K_W-1:0]         part_k_reg;
    logic [BIT_W-1:0]       low_mask;
    logic [BIT_W+POOL_W-1:0] pool_sh;
    logic [BIT_W-1:0]       bit_idx_next;
    logic [BIT_W-1:0]       bit_idx_reg;
    logic                   pool_ok_next;
    logic                   pool_ok_reg;
    logic [NONCE_W-1:0]     lag_reg;
    logic [CMP_W-1:0]       win;
    logic                   ovf_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [CELL_AW-1:0]     cell_reg;
    logic [BIT_W-1:0]       base_w;
    logic [OFF_W-1:0]       off_reg;

    // bitmap memory
    logic [CELL_BITS-1:0]   mem [NUM_CELLS];
    logic [CELL_BITS-1:0]   rd_data_reg;
    logic [CELL_AW-1:0]     clr_cnt_reg;
    logic                   mem_we;
    logic [CELL_AW-1:0]     mem_waddr;
    logic [CELL_BITS-1:0]   mem_wdata;
    logic [CELL_BITS-1:0]   bit_mask;
    logic                   bit_seen;

    // result
    logic [STATUS_W-1:0]    stat_next;
    logic [STATUS_W-1:0]    stat_reg;
    logic                   write_ok;
    logic                   m_tvalid_reg;
    logic [STATUS_W-1:0]    status_out_reg;
    logic [NONCE_W-1:0]     id_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_bits_reg <= '0;
        end
        else if (cfg_we)
        begin
            pool_bits_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg  <= func;
            nonce_reg <= nonce_id;
            pool_reg  <= pool;
            cur_reg   <= current_id;
        end
    end

    // stage 1: partition geometry, bit index and id lag
    always_comb
    begin
        if ({1'b0, pool_bits_reg} > (POOL_BITS_W+1)'(IN_FLIGHT_LOG2))
        begin
            pb_eff = POOL_BITS_W'(IN_FLIGHT_LOG2);
        end
        else
        begin
            pb_eff = pool_bits_reg;
        end
        part_k_next  = K_W'(IN_FLIGHT_LOG2) - K_W'(pb_eff);
        low_mask     = {BIT_W{1'b1}} >> pb_eff;
        pool_sh      = (BIT_W+POOL_W)'(pool_reg) << part_k_next;
        bit_idx_next = (nonce_reg[BIT_W-1:0] & low_mask) + pool_sh[BIT_W-1:0];
        pool_ok_next = ((pool_reg >> pb_eff) == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.calc1)
        begin
            part_k_reg  <= part_k_next;
            bit_idx_reg <= bit_idx_next;
            pool_ok_reg <= pool_ok_next;
            lag_reg     <= cur_reg - nonce_reg;
        end
    end

    // stage 2: window compare at full width, reciprocal product
    assign win = CMP_W'(ID_STEP) << part_k_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.calc2)
        begin
            ovf_reg  <= (CMP_W'(lag_reg) >= win);
            prod_reg <= PROD_W'(bit_idx_reg) * PROD_W'(RECIP);
        end
    end

    // stage 3: cell number
    always_ff @(posedge clk)
    begin
        if (cmd.calc3)
        begin
            cell_reg <= prod_reg[SH +: CELL_AW];
        end
    end

    // stage 4: bit offset inside the cell, memory read
    assign base_w = BIT_W'(cell_reg) * BIT_W'(CELL_BITS);

    always_ff @(posedge clk)
    begin
        if (cmd.calc4)
        begin
            off_reg <= OFF_W'(bit_idx_reg - base_w);
        end
    end

    // stage 5: status and write-back
    assign bit_mask = CELL_BITS'(1) << off_reg;
    assign bit_seen = |(rd_data_reg & bit_mask);

    always_comb
    begin
        stat_next = STAT_OK;
        write_ok  = 1'b0;
        mem_wdata = rd_data_reg | bit_mask;
        if (!pool_ok_reg)
        begin
            stat_next = STAT_BAD_POOL;
        end
        else if (func_reg == FUNC_ISSUE)
        begin
            write_ok  = 1'b1;
            mem_wdata = rd_data_reg & ~bit_mask;
        end
        else if (ovf_reg)
        begin
            stat_next = STAT_OVERFLOW;
        end
        else if (bit_seen)
        begin
            stat_next = STAT_REPLAY;
        end
        else
        begin
            write_ok = 1'b1;
        end
        if (cmd.clear)
        begin
            mem_wdata = '1;
        end
    end

    assign mem_we    = cmd.clear || (cmd.modify && write_ok);
    assign mem_waddr = cmd.clear ? clr_cnt_reg : cell_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.modify)
        begin
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.calc4)
        begin
            rd_data_reg <= mem[cell_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + CELL_AW'(1);
        end
    end

    assign sts.clr_last = (clr_cnt_reg == CELL_AW'(NUM_CELLS - 1));

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_out_reg <= stat_reg;
            id_out_reg     <= nonce_reg;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign status       = status_out_reg;
    assign id_echo      = id_out_reg;

    // reciprocal split must give a cell base at or below the index and within one cell
    `OTN_ASSERT_IMP(a_split_exact, clk, rst_n, cmd.calc4, (base_w <= bit_idx_reg) && ((bit_idx_reg - base_w) < BIT_W'(CELL_BITS)))
    `OTN_ASSERT_IMP(a_no_result_overwrite, clk, rst_n, cmd.load_out, !m_tvalid_reg || m_tready)

endmodule

// ===== rtl/core/one_time_nonce_replay_bitmap_top.sv =====
// nonce replay bitmap top level; depends on otn_pkg, otn_ctrl, otn_datapath
// one request at a time: the next request beat is taken only after the result beat is
//   handed to the output register, which waits while a previous result is not yet taken;
//   the controller walks each request through the index arithmetic, one bitmap read and one write-back of its cell
// reset: async active low; then a sweep over 2^IN_FLIGHT_LOG2 / CELL_BITS cells, rounded up
//   (2048 at defaults), sets every bitmap bit before the first request is taken
module one_time_nonce_replay_bitmap_top
    import otn_pkg::*;
#(
    parameter int IN_FLIGHT_LOG2 = 16,
    parameter int CELL_BITS      = 32,
    parameter int ID_STEP        = 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // pool_bits register write
    input  logic                   cfg_we,
    input  logic [POOL_BITS_W-1:0] cfg_wdata,
    // request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // nonce_id[31:0], pool[41:32], current_id[73:42], zero pad
    input  logic                   s_tuser,   // func: issue or check
    // result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata    // status[1:0], id_echo[33:2], zero pad
);

    otn_cmd_t            cmd;
    otn_sts_t            sts;
    logic [STATUS_W-1:0] status;
    logic [NONCE_W-1:0]  id_echo;

    // request beat unpacking
    logic [NONCE_W-1:0]  in_nonce;
    logic [POOL_W-1:0]   in_pool;
    logic [NONCE_W-1:0]  in_cur;

    assign in_nonce = s_tdata[NONCE_W-1:0];
    assign in_pool  = s_tdata[NONCE_W +: POOL_W];
    assign in_cur   = s_tdata[NONCE_W+POOL_W +: NONCE_W];

    // sequencing: sweep, accept, four arithmetic steps, read-modify-write, hand-off
    otn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // arithmetic, bitmap memory and the result register that decouples the output side
    otn_datapath #(
        .IN_FLIGHT_LOG2 (IN_FLIGHT_LOG2),
        .CELL_BITS      (CELL_BITS),
        .ID_STEP        (ID_STEP)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .func       (s_tuser),
        .nonce_id   (in_nonce),
        .pool       (in_pool),
        .current_id (in_cur),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .status     (status),
        .id_echo    (id_echo),
        .cmd        (cmd),
        .sts        (sts)
    );

    // result beat packing
    assign m_tdata = {(M_TDATA_W-STATUS_W-NONCE_W)'(0), id_echo, status};

endmodule
